### hw/rtl/kpc_pkg.sv
`default_nettype none

package kpc_pkg;

  // Result event codes.
  typedef enum logic [2:0] {
    EV_NONE       = 3'd0,
    EV_BOOT_SHORT = 3'd1,
    EV_BOOT_LONG  = 3'd2,
    EV_BOOT_HOLD  = 3'd3,
    EV_POWER_HOLD = 3'd4
  } key_event_t;

  // Configuration register indexes.
  localparam int CfgIndexWidth = 2;
  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_SHORT_LIMIT = 2'd0,
    CFG_HOLD_LIMIT  = 2'd1,
    CFG_LONG_LIMIT  = 2'd2
  } cfg_reg_t;

  localparam int TimeWidth  = 32;
  localparam int LimitWidth = 16;

  localparam logic [LimitWidth-1:0] ShortLimitReset = 16'd1000;
  localparam logic [LimitWidth-1:0] HoldLimitReset  = 16'd3000;
  localparam logic [LimitWidth-1:0] LongLimitReset  = 16'd5000;

  typedef struct packed {
    logic [LimitWidth-1:0] short_limit;
    logic [LimitWidth-1:0] hold_limit;
    logic [LimitWidth-1:0] long_limit;
  } kpc_limits_t;

  // Per-key event flags reported by one key tracker for the current tick.
  typedef struct packed {
    logic short_ev;
    logic hold_ev;
    logic long_ev;
  } kpc_key_ev_t;

endpackage

`default_nettype wire

### hw/rtl/key_press_classifier_core.sv
// Channel | Signals                                      | Direction
// poll    | in_valid, in_stall, now_ms, boot/power_pressed | in (stall out)
// event   | out_valid, out_stall, key_event              | out (stall in)
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data    | in (ready out)
//
// A poll transfer is registered, then classified and written to the
// event register, and one poll can be taken every cycle unless a
// stalled event holds the pipe. Throughput is set by the single classify
// stage between the input and event registers. The synchronous reset
// clears both valid flags, all key flags, and loads the default limits.
// A stalled event holds the classify stage, and the input register takes
// a new transfer only when it is empty or moving forward in that cycle.
`default_nettype none

module key_press_classifier_core
  import kpc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [TimeWidth-1:0]     now_ms,
  input  wire logic                     boot_pressed,
  input  wire logic                     power_pressed,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [2:0]                    key_event,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [LimitWidth-1:0]    cfg_data
);

  kpc_limits_t limits;

  // Input register.
  logic                 s1_valid;
  logic [TimeWidth-1:0] s1_now;
  logic                 s1_boot;
  logic                 s1_power;

  // The classify stage moves when the event register is empty or its
  // current event is being taken in this cycle.
  logic advance;
  logic classify;
  logic power_step;

  kpc_key_ev_t boot_ev;
  kpc_key_ev_t power_ev;
  logic        boot_any;
  key_event_t  event_next;

  assign advance    = !out_valid || !out_stall;
  assign in_stall   = s1_valid && !advance;
  assign classify   = s1_valid && advance;
  assign boot_any   = boot_ev.short_ev || boot_ev.hold_ev || boot_ev.long_ev;
  // The power key is only polled when the boot key reports nothing.
  assign power_step = classify && !boot_any;

  kpc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .limits    (limits)
  );

  kpc_key #(.HasLong(1'b1)) u_boot (
    .clk     (clk),
    .rst     (rst),
    .step    (classify),
    .pressed (s1_boot),
    .now_ms  (s1_now),
    .limits  (limits),
    .ev      (boot_ev)
  );

  // The power key has no long hold, and its short press is not reported.
  kpc_key #(.HasLong(1'b0)) u_power (
    .clk     (clk),
    .rst     (rst),
    .step    (power_step),
    .pressed (s1_power),
    .now_ms  (s1_now),
    .limits  (limits),
    .ev      (power_ev)
  );

  always_comb begin
    if (boot_ev.short_ev) begin
      event_next = EV_BOOT_SHORT;
    end else if (boot_ev.hold_ev) begin
      event_next = EV_BOOT_HOLD;
    end else if (boot_ev.long_ev) begin
      event_next = EV_BOOT_LONG;
    end else if (power_ev.hold_ev) begin
      event_next = EV_POWER_HOLD;
    end else begin
      event_next = EV_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_now   <= now_ms;
      s1_boot  <= boot_pressed;
      s1_power <= power_pressed;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (classify) begin
      key_event <= event_next;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kpc_key.sv
`default_nettype none

module kpc_key
  import kpc_pkg::*;
#(
  parameter bit HasLong = 1'b1
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic                 pressed,
  input  wire logic [TimeWidth-1:0] now_ms,
  input  wire kpc_limits_t          limits,
  output kpc_key_ev_t               ev
);

  logic                 down;
  logic                 armed;
  logic                 hold_fired;
  logic                 long_fired;
  logic [TimeWidth-1:0] press_time;

  logic                 down_next;
  logic                 armed_next;
  logic                 hold_fired_next;
  logic                 long_fired_next;
  logic [TimeWidth-1:0] press_time_next;

  logic [TimeWidth-1:0] elapsed;
  logic                 upper_zero;
  logic                 below_short;
  logic                 reach_hold;
  logic                 reach_long;

  // Elapsed time wraps modulo 2^32; limits are 16 bits, so the upper half
  // of the elapsed time decides the compares whenever it is nonzero.
  assign elapsed     = now_ms - press_time;
  assign upper_zero  = (elapsed[TimeWidth-1:LimitWidth] == '0);
  assign below_short = upper_zero && (elapsed[LimitWidth-1:0] < limits.short_limit);
  assign reach_hold  = !upper_zero || (elapsed[LimitWidth-1:0] >= limits.hold_limit);
  assign reach_long  = !upper_zero || (elapsed[LimitWidth-1:0] >= limits.long_limit);

  always_comb begin
    down_next       = down;
    armed_next      = armed;
    hold_fired_next = hold_fired;
    long_fired_next = long_fired;
    press_time_next = press_time;
    ev              = '0;
    if (!pressed) begin
      ev.short_ev     = down && !hold_fired && below_short;
      down_next       = 1'b0;
      armed_next      = 1'b1;
      hold_fired_next = 1'b0;
      long_fired_next = 1'b0;
    end else if (!down) begin
      down_next       = 1'b1;
      press_time_next = now_ms;
    end else if (armed) begin
      if (!hold_fired && reach_hold) begin
        hold_fired_next = 1'b1;
        ev.hold_ev      = 1'b1;
      end else if (HasLong && hold_fired && !long_fired && reach_long) begin
        long_fired_next = 1'b1;
        ev.long_ev      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down       <= 1'b0;
      armed      <= 1'b0;
      hold_fired <= 1'b0;
      press_time <= '0;
    end else if (step) begin
      down       <= down_next;
      armed      <= armed_next;
      hold_fired <= hold_fired_next;
      press_time <= press_time_next;
    end
  end

  generate
    if (HasLong) begin : g_long
      always_ff @(posedge clk) begin
        if (rst) begin
          long_fired <= 1'b0;
        end else if (step) begin
          long_fired <= long_fired_next;
        end
      end
    end else begin : g_no_long
      assign long_fired = 1'b0;
    end
  endgenerate

endmodule

`default_nettype wire

### hw/rtl/kpc_cfg.sv
`default_nettype none

module kpc_cfg
  import kpc_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_valid,
  output logic                          cfg_ready,
  input  wire logic [CfgIndexWidth-1:0] cfg_index,
  input  wire logic [LimitWidth-1:0]    cfg_data,
  output kpc_limits_t                   limits
);

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.short_limit <= ShortLimitReset;
      limits.hold_limit  <= HoldLimitReset;
      limits.long_limit  <= LongLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SHORT_LIMIT: limits.short_limit <= cfg_data;
        CFG_HOLD_LIMIT:  limits.hold_limit  <= cfg_data;
        CFG_LONG_LIMIT:  limits.long_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hw/rtl/kpc_checker.sv
`default_nettype none

module kpc_checker
  import kpc_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] key_event
);

  // Reset empties the event register.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("event valid after reset");

  // With no event waiting, the block always takes a poll.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("poll stalled while event register empty");

  // A stalled event holds.
  a_event_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(key_event))
    else $error("stalled event changed");

  // Only defined event codes are delivered.
  a_event_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (key_event == EV_NONE || key_event == EV_BOOT_SHORT ||
                   key_event == EV_BOOT_LONG || key_event == EV_BOOT_HOLD ||
                   key_event == EV_POWER_HOLD))
    else $error("undefined event code");

endmodule

bind key_press_classifier_core kpc_checker u_kpc_checker (.*);

`default_nettype wire
